FILE: hw/rtl/rmss_pkg.sv
package rmss_pkg;
  localparam int SampleBits = 16;
  localparam int CountBits  = 24;
  localparam int MeanBits   = 32;
  localparam int SumBits    = 64;
  localparam int SigBits    = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MDIV,
    ST_EVAL,
    ST_MUL,
    ST_ACC,
    ST_SDIV,
    ST_SQRT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic first;
    logic full;
    logic mdiv_start;
    logic eval;
    logic mul_step;
    logic acc;
    logic sdiv_start;
    logic sqrt_start;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic is_full;
    logic is_first;
    logic done;
  } sts_t;
endpackage

FILE: hw/rtl/rmss_ctrl.sv
module rmss_ctrl
  import rmss_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  state_e state_q, state_d;
  logic   ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

  always_comb begin
    state_d    = state_q;
    ov_d       = ov_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = ov_q;
        if (in_valid_i && !ov_q) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MDIV;
        end
      end
      ST_MDIV: begin
        if (sts_i.is_full) begin
          cmd_o.full = 1'b1;
          state_d    = ST_OUT;
        end else if (sts_i.is_first) begin
          cmd_o.first = 1'b1;
          state_d     = ST_OUT;
        end else begin
          cmd_o.mdiv_start = 1'b1;
          state_d          = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.step = 1'b1;
        if (sts_i.done) begin
          cmd_o.eval = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.done) state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_d) begin
          cmd_o.sdiv_start = 1'b1;
          state_d          = ST_SDIV;
        end
      end
      ST_SDIV: begin
        cmd_o.step = 1'b1;
        if (sts_i.done) begin
          cmd_o.sqrt_start = 1'b1;
          state_d          = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd_o.step = 1'b1;
        if (sts_i.done) begin
          ov_d    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

FILE: hw/rtl/rmss_dp.sv
module rmss_dp
  import rmss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic [SampleBits-1:0] sample_i,
  output logic [CountBits-1:0]  sample_count_o,
  output logic [SampleBits-1:0] smallest_o,
  output logic [SampleBits-1:0] largest_o,
  output logic [MeanBits-1:0]   mean_value_o,
  output logic [SigBits-1:0]    sigma_value_o,
  output logic                  count_full_o
);
  localparam int XB = SampleBits + 17;
  localparam int DB = XB + 2;
  localparam int MB = DB - 1;
  localparam int PB = 2 * MB;

  logic [CountBits-1:0]         n_q;
  logic signed [SampleBits-1:0] mn_q, mx_q, s_q;
  logic signed [MeanBits-1:0]   mean_q;
  logic [SumBits-1:0]           sum_q;
  logic [SigBits-1:0]           sig_q;
  logic                         full_q;
  logic signed [DB-1:0]         d_q;
  logic [MB-1:0]                rem_q, quo_q, mb_q;
  logic [PB-1:0]                prod_q;
  logic [SumBits+CountBits-1:0] sdr_q;
  logic [SumBits-1:0]           squo_q;
  logic [SumBits-1:0]           sv_q, sres_q;
  logic [6:0]                   cnt_q;
  logic                         dneg_q, zero_inc_q;
  logic [1:0]                   ph_q;

  logic signed [DB-1:0] x_w, d_w, nm_w, e_w;
  logic [MB-1:0]        dmag_w, emag_w;
  logic [CountBits:0]   np1_w;
  logic [MB:0]          rsh_w;
  logic [MB+1:0]        rsub_w;
  logic [CountBits:0]   nm1_w;
  logic [CountBits+1:0] ssub_w;
  logic [SumBits:0]     sadd_w;
  logic [SumBits-1:0]   inc_w;
  logic [4:0]           cm1_w;
  logic [SumBits-1:0]   sqb_w;
  logic [SumBits:0]     sqt_w;

  function automatic logic signed [DB-1:0] sat(input logic signed [DB-1:0] v);
    logic signed [DB-1:0] hi, lo;
    hi = DB'(signed'({1'b0, {(MeanBits-1){1'b1}}}));
    lo = DB'(signed'({1'b1, {(MeanBits-1){1'b0}}}));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic logic state_div();
    return ph_q == 2'd1 && cnt_q != '0;
  endfunction
  function automatic logic sdiv_run();
    return ph_q == 2'd2 && cnt_q != '0;
  endfunction
  function automatic logic sqrt_run();
    return ph_q == 2'd3 && cnt_q != '0;
  endfunction

  assign x_w    = DB'(signed'(s_q)) <<< 16;
  assign d_w    = x_w - DB'(mean_q);
  assign dmag_w = d_w[DB-1] ? MB'(-d_w) : MB'(d_w);
  assign np1_w  = {1'b0, n_q} + 1'b1;
  assign rsh_w  = {rem_q, quo_q[MB-1]};
  assign rsub_w = {1'b0, rsh_w} - (MB+2)'(np1_w);
  assign nm_w   = dneg_q ? (DB'(mean_q) - DB'(quo_q)) : (DB'(mean_q) + DB'(quo_q));
  assign e_w    = x_w - sat(nm_w);
  assign emag_w = e_w[DB-1] ? MB'(-e_w) : MB'(e_w);
  assign nm1_w  = {1'b0, n_q} - 1'b1;
  assign ssub_w = {1'b0, sdr_q[SumBits+CountBits-1:SumBits-1]} - (CountBits+2)'(nm1_w);
  assign inc_w  = zero_inc_q ? '0 : SumBits'(prod_q >> 24);
  assign sadd_w = {1'b0, sum_q} + {1'b0, inc_w};
  assign cm1_w  = cnt_q[4:0] - 5'd1;
  assign sqb_w  = {{(SumBits-1){1'b0}}, 1'b1} << {cm1_w, 1'b0};
  assign sqt_w  = {1'b0, sres_q} + {1'b0, sqb_w};

  always_comb begin
    sts_o.is_full  = &n_q;
    sts_o.is_first = n_q == '0;
    sts_o.done     = cnt_q == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ph_q <= '0;
    else if (cmd_i.mdiv_start) ph_q <= 2'd1;
    else if (cmd_i.sdiv_start || cmd_i.eval) ph_q <= 2'd2;
    else if (cmd_i.sqrt_start) ph_q <= 2'd3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      mn_q   <= '0;
      mx_q   <= '0;
      mean_q <= '0;
      sum_q  <= '0;
      sig_q  <= '0;
      full_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.load) s_q <= sample_i;
      if (cmd_i.full) full_q <= 1'b1;
      if (cmd_i.first) begin
        full_q <= 1'b0;
        mn_q   <= s_q;
        mx_q   <= s_q;
        mean_q <= MeanBits'(sat(x_w));
        sum_q  <= '0;
        n_q    <= n_q + 1'b1;
      end
      if (cmd_i.mdiv_start) begin
        full_q <= 1'b0;
        d_q    <= d_w;
        dneg_q <= d_w[DB-1];
        quo_q  <= dmag_w;
        rem_q  <= '0;
        cnt_q  <= 7'(MB);
        if (s_q < mn_q) mn_q <= s_q;
        if (s_q > mx_q) mx_q <= s_q;
      end
      if (cmd_i.step && cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (cmd_i.step && !cmd_i.eval && state_div()) begin
        if (!rsub_w[MB+1]) rem_q <= MB'(rsub_w);
        else rem_q <= MB'(rsh_w);
        quo_q <= {quo_q[MB-2:0], ~rsub_w[MB+1]};
      end
      if (cmd_i.eval) begin
        zero_inc_q <= (d_q > 0 && e_w < 0) || (d_q < 0 && e_w > 0);
        mean_q     <= MeanBits'(sat(nm_w));
        prod_q     <= '0;
        mb_q       <= emag_w;
        rem_q      <= MB'(d_q[DB-1] ? -d_q : d_q);
        cnt_q      <= 7'(MB);
      end
      if (cmd_i.mul_step) begin
        if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
        if (cnt_q != '0) begin
          prod_q <= (prod_q << 1) + (mb_q[MB-1] ? PB'(rem_q) : '0);
          mb_q   <= mb_q << 1;
        end
      end
      if (cmd_i.acc) begin
        sum_q <= sadd_w[SumBits] ? '1 : sadd_w[SumBits-1:0];
        n_q   <= n_q + 1'b1;
      end
      if (cmd_i.sdiv_start) begin
        sdr_q  <= {{CountBits{1'b0}}, sum_q};
        squo_q <= '0;
        cnt_q  <= 7'(SumBits);
      end
      if (cmd_i.step && sdiv_run()) begin
        if (!ssub_w[CountBits+1])
          sdr_q <= {ssub_w[CountBits-1:0], sdr_q[SumBits-2:0], 1'b0};
        else
          sdr_q <= sdr_q << 1;
        squo_q <= {squo_q[SumBits-2:0], ~ssub_w[CountBits+1]};
      end
      if (cmd_i.sqrt_start) begin
        sv_q   <= {squo_q[SumBits-25:0], 24'd0};
        sres_q <= '0;
        cnt_q  <= 7'd32;
        sig_q  <= (n_q < 2) ? '0 : (|squo_q[SumBits-1:40]) ? '1 : '0;
      end
      if (cmd_i.step && sqrt_run()) begin
        if (sv_q >= sqt_w[SumBits-1:0] && !sqt_w[SumBits]) begin
          sv_q   <= sv_q - sqt_w[SumBits-1:0];
          sres_q <= (sres_q >> 1) + sqb_w;
        end else begin
          sres_q <= sres_q >> 1;
        end
        if (cnt_q == 7'd1 && n_q >= 2 && !(|squo_q[SumBits-1:40]))
          sig_q <= SigBits'(((sv_q >= sqt_w[SumBits-1:0]) ?
                   (sres_q >> 1) + sqb_w : sres_q >> 1));
      end
    end
  end

  assign sample_count_o = n_q;
  assign smallest_o     = mn_q;
  assign largest_o      = mx_q;
  assign mean_value_o   = mean_q;
  assign sigma_value_o  = sig_q;
  assign count_full_o   = full_q;
endmodule

FILE: hw/rtl/running_mean_sigma_stats.sv
// channel  signals                                    direction
// in       in_valid_i, in_stall_o, sample_i           to block
// out      out_valid_o, out_stall_i, sample_count_o,  from block
//          smallest_o, largest_o, mean_value_o,
//          sigma_value_o, count_full_o
// from accept to out_valid_o: mean division, multiply, sum/(n-1) division, square root;
// a first sample or full count skips the mean division and the multiply
// reset clears all statistics; in_stall_o is high while a sample is in work
// a held result blocks the next sample until it is taken; the next sample
// is accepted in the cycle after the result transaction at the earliest
module running_mean_sigma_stats
  import rmss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [SampleBits-1:0] sample_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CountBits-1:0]  sample_count_o,
  output logic [SampleBits-1:0] smallest_o,
  output logic [SampleBits-1:0] largest_o,
  output logic [MeanBits-1:0]   mean_value_o,
  output logic [SigBits-1:0]    sigma_value_o,
  output logic                  count_full_o
);
  cmd_t cmd;
  sts_t sts;

  rmss_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  rmss_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .sample_i,
    .sample_count_o, .smallest_o, .largest_o, .mean_value_o,
    .sigma_value_o, .count_full_o
  );
endmodule
